// ===== sv/assert_macros.svh =====
// Assertion macros used by the barometer compensation top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define ASSERT_NOW(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("assertion failed");
// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_NOW(lbl, clk, rstn, cond)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/bcmp_pkg.sv =====
// Shared widths and types of the barometer compensation pipeline.
`default_nettype none
package bcmp_pkg;

  // Magnitude widths of the pressure dividend and divisor
  localparam int NMAG_W = 76;
  localparam int DMAG_W = 40;

  // Quotient bits resolved per divider stage
  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = NMAG_W / DIV_BPS;

  // Side information that travels with an item through the divider
  typedef struct packed {
    logic               vld;
    logic               dz;
    logic               qneg;
    logic signed [15:0] cent;
  } bcmp_side_t;

endpackage
`default_nettype wire

// ===== sv/bcmp_div.sv =====
// Pipelined restoring divider, a fixed number of quotient bits per stage.
`default_nettype none
module bcmp_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          adv,
  input  wire bcmp_pkg::bcmp_side_t          side_i,
  input  wire logic [bcmp_pkg::NMAG_W-1:0]   nmag_i,
  input  wire logic [bcmp_pkg::DMAG_W-1:0]   dmag_i,
  output bcmp_pkg::bcmp_side_t               side_o,
  output logic      [bcmp_pkg::NMAG_W-1:0]   quo_o
);

  localparam int NW = bcmp_pkg::NMAG_W;
  localparam int DW = bcmp_pkg::DMAG_W;
  localparam int NS = bcmp_pkg::DIV_STAGES;

  bcmp_pkg::bcmp_side_t side_r [NS];
  logic [NW-1:0]        num_r  [NS];
  logic [DW-1:0]        rem_r  [NS];
  logic [DW-1:0]        den_r  [NS];

  for (genvar g = 0; g < NS; g++) begin : g_st
    bcmp_pkg::bcmp_side_t side_in;
    logic [NW-1:0]        num_in;
    logic [NW-1:0]        num_nxt;
    logic [DW-1:0]        rem_in;
    logic [DW-1:0]        rem_nxt;
    logic [DW-1:0]        den_in;

    // Select stage input: ports for the first stage, previous stage otherwise
    if (g == 0) begin : g_first
      assign side_in = side_i;
      assign num_in  = nmag_i;
      assign rem_in  = '0;
      assign den_in  = dmag_i;
    end else begin : g_next
      assign side_in = side_r[g-1];
      assign num_in  = num_r[g-1];
      assign rem_in  = rem_r[g-1];
      assign den_in  = den_r[g-1];
    end

    // Shift in dividend bits, subtract where the divisor fits
    always_comb begin : step
      logic [DW:0]   trial;
      logic [NW-1:0] n;
      logic [DW-1:0] rm;
      n  = num_in;
      rm = rem_in;
      for (int k = 0; k < bcmp_pkg::DIV_BPS; k++) begin
        trial = {rm, n[NW-1]};
        n     = {n[NW-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          trial = trial - {1'b0, den_in};
          n[0]  = 1'b1;
        end
        rm = trial[DW-1:0];
      end
      num_nxt = n;
      rem_nxt = rm;
    end

    // Advance side information, valid bit cleared by reset
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[g] <= '0;
      end else if (adv) begin
        side_r[g] <= side_in;
      end
    end

    // Advance the datapath
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[g] <= num_nxt;
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
      end
    end
  end

  assign side_o = side_r[NS-1];
  assign quo_o  = num_r[NS-1];

endmodule
`default_nettype wire

// ===== sv/barometer_temp_pressure_compensation.sv =====
// Top level of the barometer temperature and pressure compensation pipeline.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  input    | in_valid / in_ready  | in_raw_temperature, in_raw_pressure
//  result   | out_valid/out_ready  | out_temperature_centi, out_pressure_q24_8,
//           |                      | out_pressure_valid
//  config   | cfg_we               | cfg_index, cfg_wdata
//
// One transfer per cycle while the output is not stalled; 12 arithmetic stages,
// 38 divider stages at two quotient bits each, 7 post-division stages.
// Synchronous active-low reset clears the calibration registers and valid bits.
// A result waiting at the output holds the whole pipeline; one more input
// transfer is taken into a skid register meanwhile, so nothing is lost.
`default_nettype none
`include "assert_macros.svh"
module barometer_temp_pressure_compensation (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [63:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [19:0]        in_raw_temperature,
  input  wire logic [19:0]        in_raw_pressure,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      out_temperature_centi,
  output logic [31:0]             out_pressure_q24_8,
  output logic                    out_pressure_valid
);

  localparam int NW = bcmp_pkg::NMAG_W;
  localparam int DW = bcmp_pkg::DMAG_W;

  typedef enum logic [1:0] {
    CFG_TEMP     = 2'd0,
    CFG_PRESS_A  = 2'd1,
    CFG_PRESS_B  = 2'd2,
    CFG_PRESS_P9 = 2'd3
  } cfg_idx_t;

  localparam logic [20:0]        PRESS_FULL = 21'd1048576;
  localparam logic signed [25:0] TF_OFFSET  = 26'sd128000;
  localparam logic signed [63:0] X_BIAS     = 64'sh0000_8000_0000_0000;
  localparam logic signed [63:0] Q_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN      = 64'sh8000_0000_0000_0000;

  // Calibration registers
  logic [47:0]        temp_cal_r;
  logic [63:0]        pcal_a_r;
  logic [63:0]        pcal_b_r;
  logic signed [15:0] pcal_p9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      pcal_a_r   <= '0;
      pcal_b_r   <= '0;
      pcal_p9_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEMP:     temp_cal_r <= cfg_wdata[47:0];
        CFG_PRESS_A:  pcal_a_r   <= cfg_wdata;
        CFG_PRESS_B:  pcal_b_r   <= cfg_wdata;
        CFG_PRESS_P9: pcal_p9_r  <= cfg_wdata[15:0];
        default:      ;
      endcase
    end
  end

  // Unpack calibration words
  logic [15:0]        c1, k1;
  logic signed [15:0] c2, c3, k2, k3, k4, k5, k6, k7, k8, k9;
  assign c1 = temp_cal_r[15:0];
  assign c2 = temp_cal_r[31:16];
  assign c3 = temp_cal_r[47:32];
  assign k1 = pcal_a_r[15:0];
  assign k2 = pcal_a_r[31:16];
  assign k3 = pcal_a_r[47:32];
  assign k4 = pcal_a_r[63:48];
  assign k5 = pcal_b_r[15:0];
  assign k6 = pcal_b_r[31:16];
  assign k7 = pcal_b_r[47:32];
  assign k8 = pcal_b_r[63:48];
  assign k9 = pcal_p9_r;

  // Flow control: the whole pipeline holds while the output waits
  logic       stall, adv, in_xfer;
  logic       skid_vld_r;
  logic [19:0] skid_rt_r, skid_rp_r;
  logic [11:0] f_vld_r;
  logic [6:0]  b_vld_r;

  assign stall    = b_vld_r[6] && !out_ready;
  assign adv      = !stall;
  assign in_ready = !skid_vld_r;
  assign in_xfer  = in_valid && in_ready;

  // Skid register: catch one transfer during a stall, drain on advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (adv) begin
      skid_vld_r <= 1'b0;
    end else if (in_xfer) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (stall && in_xfer) begin
      skid_rt_r <= in_raw_temperature;
      skid_rp_r <= in_raw_pressure;
    end
  end

  logic        src_vld;
  logic [19:0] src_rt, src_rp;
  assign src_vld = skid_vld_r || in_xfer;
  assign src_rt  = skid_vld_r ? skid_rt_r : in_raw_temperature;
  assign src_rp  = skid_vld_r ? skid_rp_r : in_raw_pressure;

  // Valid bits of the arithmetic and post-division stages
  bcmp_pkg::bcmp_side_t dv_side_in, dv_side;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= '0;
      b_vld_r <= '0;
    end else if (adv) begin
      f_vld_r <= {f_vld_r[10:0], src_vld};
      b_vld_r <= {b_vld_r[5:0], dv_side.vld};
    end
  end

  // Stage 1: temperature differences
  logic signed [18:0] da_c;
  logic signed [17:0] db_c;
  logic signed [18:0] s1_da_r;
  logic signed [17:0] s1_db_r;
  logic [19:0]        s1_rp_r;
  assign da_c = 19'(src_rt[19:3]) - 19'({c1, 1'b0});
  assign db_c = 18'(src_rt[19:4]) - 18'(c1);

  // Stage 2: linear product and square
  logic [15:0]        dba_c;
  logic signed [34:0] s2_p1_r;
  logic [31:0]        s2_sq_r;
  logic [19:0]        s2_rp_r;
  assign dba_c = s1_db_r[17] ? 16'(-s1_db_r) : 16'(s1_db_r);

  // Stage 3: scaled terms
  logic signed [23:0] s3_t1_r;
  logic signed [36:0] s3_q2_r;
  logic [19:0]        s3_rp_r;

  // Stage 4: fine temperature
  logic signed [24:0] s4_tf_r;
  logic [19:0]        s4_rp_r;

  // Stage 5: centidegrees with saturation, pressure offset
  logic signed [27:0] c5_c;
  logic signed [19:0] centw_c;
  logic signed [15:0] cent_c;
  logic signed [15:0] s5_cent_r;
  logic signed [25:0] s5_dt_r;
  logic [19:0]        s5_rp_r;
  assign c5_c    = 28'(s4_tf_r) * 28'sd5 + 28'sd128;
  assign centw_c = 20'(c5_c >>> 8);
  always_comb begin
    if (centw_c > 20'sd32767) begin
      cent_c = 16'sh7FFF;
    end else if (centw_c < -20'sd32768) begin
      cent_c = 16'sh8000;
    end else begin
      cent_c = 16'(centw_c);
    end
  end

  // Stage 6: square and linear products of the offset
  logic [23:0]        dta_c;
  logic [47:0]        s6_dd_r;
  logic signed [41:0] s6_dtk5_r, s6_dtk2_r;
  logic signed [15:0] s6_cent_r;
  logic [19:0]        s6_rp_r;
  assign dta_c = s5_dt_r[25] ? 24'(-s5_dt_r) : 24'(s5_dt_r);

  // Stage 7: second-order products
  logic signed [63:0] s7_ddk6_r, s7_ddk3_r;
  logic signed [41:0] s7_dtk5_r, s7_dtk2_r;
  logic signed [15:0] s7_cent_r;
  logic [19:0]        s7_rp_r;

  // Stage 8: offset and sensitivity sums
  logic signed [63:0] s8_lin_r, s8_quad_r;
  logic signed [15:0] s8_cent_r;
  logic [19:0]        s8_rp_r;

  // Stage 9: split sensitivity, form numerator
  logic signed [63:0] x_c, pr_c;
  logic signed [30:0] s9_xh_r;
  logic [32:0]        s9_xl_r;
  logic signed [63:0] s9_num_r;
  logic signed [15:0] s9_cent_r;
  assign x_c  = s8_quad_r + X_BIAS;
  assign pr_c = $signed({12'd0, PRESS_FULL - 21'(s8_rp_r), 31'd0});

  // Stage 10: divisor partial products, scaled numerator
  logic signed [47:0] s10_xhk1_r;
  logic [48:0]        s10_xlk1_r;
  logic signed [76:0] s10_n3_r;
  logic signed [15:0] s10_cent_r;

  // Stage 11: divisor, numerator magnitude
  logic signed [47:0] s11_den_r;
  logic [NW-1:0]      s11_nmag_r;
  logic               s11_nneg_r;
  logic signed [15:0] s11_cent_r;

  // Stage 12: divisor magnitude, signs, zero check
  logic [DW-1:0]      s12_dmag_r;
  logic [NW-1:0]      s12_nmag_r;
  logic               s12_dz_r, s12_qneg_r;
  logic signed [15:0] s12_cent_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_da_r    <= da_c;
      s1_db_r    <= db_c;
      s1_rp_r    <= src_rp;

      s2_p1_r    <= 35'(s1_da_r) * 35'(c2);
      s2_sq_r    <= 32'(dba_c) * 32'(dba_c);
      s2_rp_r    <= s1_rp_r;

      s3_t1_r    <= 24'(s2_p1_r >>> 11);
      s3_q2_r    <= 37'($signed({1'b0, s2_sq_r[31:12]})) * 37'(c3);
      s3_rp_r    <= s2_rp_r;

      s4_tf_r    <= 25'(s3_t1_r) + 25'(s3_q2_r >>> 14);
      s4_rp_r    <= s3_rp_r;

      s5_cent_r  <= cent_c;
      s5_dt_r    <= 26'(s4_tf_r) - TF_OFFSET;
      s5_rp_r    <= s4_rp_r;

      s6_dd_r    <= 48'(dta_c) * 48'(dta_c);
      s6_dtk5_r  <= 42'(s5_dt_r) * 42'(k5);
      s6_dtk2_r  <= 42'(s5_dt_r) * 42'(k2);
      s6_cent_r  <= s5_cent_r;
      s6_rp_r    <= s5_rp_r;

      s7_ddk6_r  <= 64'($signed({1'b0, s6_dd_r})) * 64'(k6);
      s7_ddk3_r  <= 64'($signed({1'b0, s6_dd_r})) * 64'(k3);
      s7_dtk5_r  <= s6_dtk5_r;
      s7_dtk2_r  <= s6_dtk2_r;
      s7_cent_r  <= s6_cent_r;
      s7_rp_r    <= s6_rp_r;

      s8_lin_r   <= s7_ddk6_r + (64'(s7_dtk5_r) <<< 17) + (64'(k4) <<< 35);
      s8_quad_r  <= (s7_ddk3_r >>> 8) + (64'(s7_dtk2_r) <<< 12);
      s8_cent_r  <= s7_cent_r;
      s8_rp_r    <= s7_rp_r;

      s9_xh_r    <= 31'(x_c >>> 33);
      s9_xl_r    <= x_c[32:0];
      s9_num_r   <= pr_c - s8_lin_r;
      s9_cent_r  <= s8_cent_r;

      s10_xhk1_r <= 48'(s9_xh_r) * 48'($signed({1'b0, k1}));
      s10_xlk1_r <= 49'(s9_xl_r) * 49'(k1);
      s10_n3_r   <= 77'(s9_num_r) * 77'sd3125;
      s10_cent_r <= s9_cent_r;

      s11_den_r  <= s10_xhk1_r + 48'($signed({1'b0, s10_xlk1_r[48:33]}));
      s11_nneg_r <= s10_n3_r[76];
      s11_nmag_r <= s10_n3_r[76] ? NW'(-s10_n3_r) : NW'(s10_n3_r);
      s11_cent_r <= s10_cent_r;

      s12_dz_r   <= (s11_den_r == 48'sd0);
      s12_dmag_r <= s11_den_r[47] ? DW'(-s11_den_r) : DW'(s11_den_r);
      s12_qneg_r <= s11_nneg_r ^ s11_den_r[47];
      s12_nmag_r <= s11_nmag_r;
      s12_cent_r <= s11_cent_r;
    end
  end

  // Divider
  logic [NW-1:0] dv_q;
  assign dv_side_in.vld  = f_vld_r[11];
  assign dv_side_in.dz   = s12_dz_r;
  assign dv_side_in.qneg = s12_qneg_r;
  assign dv_side_in.cent = s12_cent_r;

  bcmp_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .side_i (dv_side_in),
    .nmag_i (s12_nmag_r),
    .dmag_i (s12_dmag_r),
    .side_o (dv_side),
    .quo_o  (dv_q)
  );

  // Post-division 1: signed quotient saturated to 64 bits
  logic signed [63:0] quo_c;
  always_comb begin
    if (!dv_side.qneg) begin
      quo_c = (|dv_q[NW-1:63]) ? Q_MAX : $signed(dv_q[63:0]);
    end else if ((|dv_q[NW-1:64]) || (dv_q[63] && (|dv_q[62:0]))) begin
      quo_c = Q_MIN;
    end else begin
      quo_c = $signed(64'd0 - dv_q[63:0]);
    end
  end

  logic signed [63:0] p1_quo_r;
  logic               p1_dz_r;
  logic signed [15:0] p1_cent_r;

  // Post-division 2: split square of the scaled quotient, linear product
  logic signed [50:0] sh_c;
  logic [50:0]        sa_c;
  assign sh_c = 51'(p1_quo_r >>> 13);
  assign sa_c = sh_c[50] ? 51'(-sh_c) : 51'(sh_c);

  logic [49:0]        p2_pah_r;
  logic [50:0]        p2_pm_r;
  logic [51:0]        p2_pal_r;
  logic signed [79:0] p2_lip_r;
  logic signed [63:0] p2_quo_r;
  logic               p2_dz_r;
  logic signed [15:0] p2_cent_r;

  // Post-division 3: full square, quotient plus linear term
  logic signed [60:0] li_c;
  assign li_c = 61'(p2_lip_r >>> 19);

  logic [100:0]       p3_sqr_r;
  logic signed [65:0] p3_qli_r;
  logic               p3_dz_r;
  logic signed [15:0] p3_cent_r;

  // Post-division 4: square times P9 in two halves
  logic signed [66:0] p4_mhi_r;
  logic signed [67:0] p4_mlo_r;
  logic signed [65:0] p4_qli_r;
  logic               p4_dz_r;
  logic signed [15:0] p4_cent_r;

  // Post-division 5: recombine halves
  logic signed [117:0] p5_sqv_r;
  logic signed [65:0]  p5_qli_r;
  logic                p5_dz_r;
  logic signed [15:0]  p5_cent_r;

  // Post-division 6: accumulate
  logic signed [93:0] p6_acc_r;
  logic               p6_dz_r;
  logic signed [15:0] p6_cent_r;

  // Post-division 7: offset, clamp and drive the output register
  logic signed [85:0] a2_c;
  logic [31:0]        press_c;
  logic               pvld_c;
  assign a2_c = 86'(p6_acc_r >>> 8) + 86'($signed({k7, 4'b0000}));
  always_comb begin
    pvld_c = 1'b1;
    if (p6_dz_r) begin
      press_c = '0;
      pvld_c  = 1'b0;
    end else if (a2_c[85]) begin
      press_c = '0;
    end else if (|a2_c[84:32]) begin
      press_c = 32'hFFFF_FFFF;
    end else begin
      press_c = a2_c[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_quo_r  <= quo_c;
      p1_dz_r   <= dv_side.dz;
      p1_cent_r <= dv_side.cent;

      p2_pah_r  <= 50'(sa_c[50:26]) * 50'(sa_c[50:26]);
      p2_pm_r   <= 51'(sa_c[50:26]) * 51'(sa_c[25:0]);
      p2_pal_r  <= 52'(sa_c[25:0]) * 52'(sa_c[25:0]);
      p2_lip_r  <= 80'(p1_quo_r) * 80'(k8);
      p2_quo_r  <= p1_quo_r;
      p2_dz_r   <= p1_dz_r;
      p2_cent_r <= p1_cent_r;

      p3_sqr_r  <= (101'(p2_pah_r) << 52) + (101'(p2_pm_r) << 27) + 101'(p2_pal_r);
      p3_qli_r  <= 66'(p2_quo_r) + 66'(li_c);
      p3_dz_r   <= p2_dz_r;
      p3_cent_r <= p2_cent_r;

      p4_mhi_r  <= 67'($signed({1'b0, p3_sqr_r[100:51]})) * 67'(k9);
      p4_mlo_r  <= 68'($signed({1'b0, p3_sqr_r[50:0]})) * 68'(k9);
      p4_qli_r  <= p3_qli_r;
      p4_dz_r   <= p3_dz_r;
      p4_cent_r <= p3_cent_r;

      p5_sqv_r  <= (118'(p4_mhi_r) <<< 51) + 118'(p4_mlo_r);
      p5_qli_r  <= p4_qli_r;
      p5_dz_r   <= p4_dz_r;
      p5_cent_r <= p4_cent_r;

      p6_acc_r  <= 94'(p5_sqv_r >>> 25) + 94'(p5_qli_r);
      p6_dz_r   <= p5_dz_r;
      p6_cent_r <= p5_cent_r;

      out_temperature_centi <= p6_cent_r;
      out_pressure_q24_8    <= press_c;
      out_pressure_valid    <= pvld_c;
    end
  end

  assign out_valid = b_vld_r[6];

  // Checks
  `ASSERT_NEXT(a_skid_load, clk, rst_n, in_valid && in_ready && stall, skid_vld_r)
  `ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_vld_r && !stall, !skid_vld_r)
  `ASSERT_NEXT(a_hold_vld, clk, rst_n, stall, $stable(f_vld_r) && $stable(b_vld_r))
  `ASSERT_NOW(a_zero_div, clk, rst_n, !(out_valid && !out_pressure_valid) || (out_pressure_q24_8 == 32'd0))

endmodule
`default_nettype wire
